// ----- rtl/core/llag_pkg.sv -----
// ----------------------------------------------------------------------------
// llag_pkg: shared types, constants and rule logic for the life-like generation unit
// Field widths, register codes, reset values and the next-state function.
// ----------------------------------------------------------------------------
package llag_pkg;

   // field widths of the item fields
   localparam int COL_W  = 9;
   localparam int ROW_W  = 12;
   localparam int MASK_W = 9;

   // stream bus widths (fields packed from bit 0, padded to whole bytes)
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_FIELD_W = 1 + COL_W + ROW_W;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   // register port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // register reset values (B3/S23)
   localparam logic [MASK_W-1:0] RESET_SURVIVE = 9'd12;
   localparam logic [MASK_W-1:0] RESET_BIRTH   = 9'd8;
   localparam logic [COL_W-1:0]  RESET_WIDTH   = 9'd404;
   localparam logic [ROW_W-1:0]  RESET_HEIGHT  = 12'd254;

   // register index, byte address 4*index
   typedef enum logic [1:0] {
      REG_SURVIVE_MASK = 2'd0,
      REG_BIRTH_MASK   = 2'd1,
      REG_GRID_WIDTH   = 2'd2,
      REG_GRID_HEIGHT  = 2'd3
   } reg_index_type;

   // one window column: top, middle, bottom
   typedef logic [2:0] column_type;

   // next state of the center cell of a 3x3 window (bit 4 is the center)
   function automatic logic next_state(input logic [8:0] window,
                                       input logic [MASK_W-1:0] survive,
                                       input logic [MASK_W-1:0] birth);
      logic [3:0]        count;
      logic [MASK_W-1:0] rule;
      count = 4'd0;
      for (int i = 0; i < 9; i++) begin
         if (i != 4) begin
            count = count + {3'd0, window[i]};
         end
      end
      rule = window[4] ? survive : birth;
      return rule[count];
   endfunction

endpackage

// ----- rtl/core/life_like_automaton_generation_unit.sv -----
// ----------------------------------------------------------------------------
// life_like_automaton_generation_unit: one generation of a life-like automaton
// Cells stream in on req_* in raster order (rows of grid_width + 2 cells,
// grid_height + 2 rows, dead border included); req_tuser marks the top-left
// border cell and clears the position counters. Each interior cell leaves on
// rsp_* with its next state, its coordinates in the updated area and
// rsp_tlast on the last interior cell of the frame; border cells give none.
// Rule masks and grid size are written through the csr_* register port; the
// user must write them only while the unit is idle, which the unit does not
// enforce. Throughput is one cell per clock unless rsp_tready holds the
// pipeline: the line buffer memory is read once and written once per cell
// and the window cells shift once per cell. An accepted cell passes the
// memory read at the accepting edge, then the window shift, then the
// output register that drives rsp_tvalid. When rsp_tready is low the
// pipeline keeps filling its empty stages and then holds req_tready low;
// no item is dropped. Reset clears the counters, window and pipeline and
// loads the B3/S23 rule, 404 x 254 grid; no clearing pass is run.
// ----------------------------------------------------------------------------
module life_like_automaton_generation_unit #(
   parameter int MAX_COLUMNS = 512,
   parameter int MAX_ROWS    = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   // input stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [llag_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [0] cell_alive
   input  logic [0:0]                         req_tuser,  // [0] frame_start
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [llag_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // [0] next_alive,
                                                          // [9:1] cell_column,
                                                          // [21:10] cell_row
   output logic                               rsp_tlast,  // frame_last
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [llag_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [llag_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [llag_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                               csr_pready
);

   localparam int COL_W = llag_pkg::COL_W;
   localparam int ROW_W = llag_pkg::ROW_W;
   localparam int LB_AW = $clog2(MAX_COLUMNS);

   // registers
   logic [llag_pkg::MASK_W-1:0] survive_ff;
   logic [llag_pkg::MASK_W-1:0] birth_ff;
   logic [COL_W-1:0]            width_ff;
   logic [ROW_W-1:0]            height_ff;
   logic                        csr_we;
   llag_pkg::reg_index_type     csr_index;

   // position counters
   logic [COL_W-1:0] col_ff, col_in, col_cur;
   logic [ROW_W-1:0] row_ff, row_in, row_cur;
   logic [COL_W:0]   last_col;
   logic [ROW_W:0]   last_row;
   logic             col_wrap, row_wrap, emit, is_last, lb_inb;

   // pipeline
   logic             accept, s1_adv, s1_free, s2_adv, s2_free, out_en;
   logic             s1_valid_ff, s1_cell_ff, s1_inb_ff, s1_emit_ff, s1_last_ff;
   logic [LB_AW-1:0] s1_addr_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s2_valid_ff, s2_emit_ff, s2_last_ff;
   logic [COL_W-1:0] s2_col_ff;
   logic [ROW_W-1:0] s2_row_ff;
   logic [1:0]       lb_data;
   logic [8:0]       window;
   llag_pkg::column_type wcol [4];

   // output register
   logic             rsp_valid_ff, rsp_alive_ff, rsp_last_ff;
   logic [COL_W-1:0] rsp_col_ff;
   logic [ROW_W-1:0] rsp_row_ff;

   // register port: writes complete in the access phase
   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = llag_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         survive_ff <= llag_pkg::RESET_SURVIVE;
         birth_ff   <= llag_pkg::RESET_BIRTH;
         width_ff   <= llag_pkg::RESET_WIDTH;
         height_ff  <= llag_pkg::RESET_HEIGHT;
      end else if (csr_we) begin
         unique case (csr_index)
            llag_pkg::REG_SURVIVE_MASK: survive_ff <= csr_pwdata[llag_pkg::MASK_W-1:0];
            llag_pkg::REG_BIRTH_MASK:   birth_ff   <= csr_pwdata[llag_pkg::MASK_W-1:0];
            llag_pkg::REG_GRID_WIDTH:   width_ff   <= csr_pwdata[COL_W-1:0];
            llag_pkg::REG_GRID_HEIGHT:  height_ff  <= csr_pwdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // register read
   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         llag_pkg::REG_SURVIVE_MASK: csr_prdata = llag_pkg::CSR_DW'(survive_ff);
         llag_pkg::REG_BIRTH_MASK:   csr_prdata = llag_pkg::CSR_DW'(birth_ff);
         llag_pkg::REG_GRID_WIDTH:   csr_prdata = llag_pkg::CSR_DW'(width_ff);
         llag_pkg::REG_GRID_HEIGHT:  csr_prdata = llag_pkg::CSR_DW'(height_ff);
         default: ;
      endcase
   end

   // handshake: each stage moves when the one after it has room
   assign out_en     = !rsp_valid_ff || rsp_tready;
   assign s2_adv     = s2_valid_ff && (!s2_emit_ff || out_en);
   assign s2_free    = !s2_valid_ff || s2_adv;
   assign s1_adv     = s1_valid_ff && s2_free;
   assign s1_free    = !s1_valid_ff || s1_adv;
   assign req_tready = s1_free;
   assign accept     = req_tvalid && req_tready;

   // position of the incoming cell and its window decision
   always_comb begin
      col_cur  = req_tuser[0] ? '0 : col_ff;
      row_cur  = req_tuser[0] ? '0 : row_ff;
      last_col = {1'b0, width_ff} + (COL_W+1)'(1);
      last_row = {1'b0, height_ff} + (ROW_W+1)'(1);
      col_wrap = ({1'b0, col_cur} >= last_col) ||
                 (32'(col_cur) + 32'd1 >= 32'(MAX_COLUMNS));
      row_wrap = ({1'b0, row_cur} >= last_row) ||
                 (32'(row_cur) + 32'd1 >= 32'(MAX_ROWS));
      emit     = (row_cur >= ROW_W'(2)) && ({1'b0, row_cur} <= last_row) &&
                 (col_cur >= COL_W'(2)) && ({1'b0, col_cur} <= last_col);
      is_last  = ({1'b0, row_cur} == last_row) && ({1'b0, col_cur} == last_col);
      lb_inb   = 32'(col_cur) < 32'(MAX_COLUMNS);
      col_in   = col_wrap ? '0 : col_cur + COL_W'(1);
      row_in   = !col_wrap ? row_cur : (row_wrap ? '0 : row_cur + ROW_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1: line buffer read in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cell_ff <= req_tdata[0];
         s1_inb_ff  <= lb_inb;
         s1_addr_ff <= LB_AW'(col_cur);
         s1_emit_ff <= emit;
         s1_last_ff <= is_last;
         s1_col_ff  <= col_cur - COL_W'(2);
         s1_row_ff  <= row_cur - ROW_W'(2);
      end
   end

   llag_line_buffer #(
      .DEPTH (MAX_COLUMNS),
      .AW    (LB_AW)
   ) u_line_buffer (
      .clock   (clock),
      .rd_en   (accept),
      .rd_inb  (lb_inb),
      .rd_addr (LB_AW'(col_cur)),
      .wr_en   (s1_adv && s1_inb_ff),
      .wr_addr (s1_addr_ff),
      .wr_data ({lb_data[0], s1_cell_ff}),
      .rd_data (lb_data)
   );

   // window: newest column enters cell 0 and moves toward cell 2
   assign wcol[0] = {lb_data[1], lb_data[0], s1_cell_ff};

   for (genvar i = 0; i < 3; i++) begin : g_window
      llag_window_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (s1_adv),
         .col_in   (wcol[i]),
         .col_out  (wcol[i+1])
      );
   end

   assign window = {wcol[3], wcol[2], wcol[1]};

   // stage 2: window complete for this item
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_adv;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_emit_ff <= s1_emit_ff;
         s2_last_ff <= s1_last_ff;
         s2_col_ff  <= s1_col_ff;
         s2_row_ff  <= s1_row_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_adv && s2_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv && s2_emit_ff) begin
         rsp_alive_ff <= llag_pkg::next_state(window, survive_ff, birth_ff);
         rsp_col_ff   <= s2_col_ff;
         rsp_row_ff   <= s2_row_ff;
         rsp_last_ff  <= s2_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{llag_pkg::RSP_PAD_W{1'b0}}, rsp_row_ff, rsp_col_ff, rsp_alive_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_counters_in_range: assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < 32'(MAX_COLUMNS)) && (32'(row_ff) < 32'(MAX_ROWS)))
      else $error("position counter beyond line buffer or frame limit");
   a_result_moves_on: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_emit_ff && s1_adv |=> s2_valid_ff && s2_emit_ff)
      else $error("item with a result lost between stages");
   a_blocked_result_held: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_emit_ff && !out_en |=>
         s2_valid_ff && $stable(s2_col_ff) && $stable(s2_row_ff))
      else $error("blocked result left the window stage");
`endif

endmodule

// ----- rtl/core/llag_window_cell.sv -----
// ----------------------------------------------------------------------------
// llag_window_cell: one column of the 3x3 neighborhood window
// Holds three cells and hands them to the next (older) column on each shift.
// ----------------------------------------------------------------------------
module llag_window_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  llag_pkg::column_type  col_in,
   output llag_pkg::column_type  col_out
);

   llag_pkg::column_type col_ff;

   // column register, shifts once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

// ----- rtl/core/llag_line_buffer.sv -----
// ----------------------------------------------------------------------------
// llag_line_buffer: two stacked line buffers in one memory
// Entry bit 1 is the upper row, bit 0 the middle row. Registered read with
// forwarding of a write to the same entry issued in the read cycle.
// ----------------------------------------------------------------------------
module llag_line_buffer #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic          rd_inb,
   input  logic [AW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [1:0]    wr_data,
   output logic [1:0]    rd_data
);

   logic [1:0]    mem [DEPTH];
   logic [1:0]    q_ff;
   logic [1:0]    fwd_data_ff;
   logic          fwd_ff;
   logic          zero_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff        <= mem[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
         zero_ff     <= !rd_inb;
      end
   end

   // columns beyond the depth read zero
   assign rd_data = zero_ff ? 2'b00 : (fwd_ff ? fwd_data_ff : q_ff);

`ifndef SYNTHESIS
   a_fwd_same_entry: assert property (@(posedge clock)
      rd_en && wr_en && (rd_addr == wr_addr) |=> fwd_ff)
      else $error("write to the entry being read not forwarded");
   a_out_of_range_zero: assert property (@(posedge clock)
      rd_en && !rd_inb |=> rd_data == 2'b00)
      else $error("out of range column did not read zero");
`endif

endmodule

// ----- tb/life_like_automaton_generation_unit_tb.sv -----
// ----------------------------------------------------------------------------
// life_like_automaton_generation_unit_tb: self-checking bench for the generation unit
// Streams whole grids with a border ring through req_*, predicts every interior
// cell's next state, coordinates and end-of-frame mark, and checks rsp_* item by
// item. Covers the power-on register values, a few hand-checked 3x3 frames,
// extreme masks and degenerate grid sizes, then random rules, sizes, densities,
// broken frames and random idling on both streams. Registers are read back
// after each write.
// ----------------------------------------------------------------------------
module life_like_automaton_generation_unit_tb;

   localparam int COL_W        = llag_pkg::COL_W;
   localparam int ROW_W        = llag_pkg::ROW_W;
   localparam int MASK_W       = llag_pkg::MASK_W;
   localparam int REQ_TDATA_W  = llag_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W  = llag_pkg::RSP_TDATA_W;
   localparam int CSR_AW       = llag_pkg::CSR_AW;
   localparam int CSR_DW       = llag_pkg::CSR_DW;
   localparam int LINE_CELLS   = 512;
   localparam int FRAME_ROWS   = 4096;
   localparam int SETTLE_TICKS = 8;
   localparam int RANDOM_CELLS = 1300;

   // one interior cell result as seen on rsp_*
   typedef struct packed {
      logic              next_alive;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
      logic              last;
   } cell_result_type;

   // hand-checked 3x3 frame on a 1x1 area; bit i is stream cell i
   typedef struct packed {
      logic [MASK_W-1:0] survive;
      logic [MASK_W-1:0] birth;
      logic [8:0]        pattern;
      logic              next_alive;
   } probe_frame_type;

   // rule and grid size for one phase
   typedef struct packed {
      logic [MASK_W-1:0] survive;
      logic [MASK_W-1:0] birth;
      logic [COL_W-1:0]  width;
      logic [ROW_W-1:0]  height;
   } grid_setting_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [0:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]      csr_paddr = '0;
   logic [CSR_DW-1:0]      csr_pwdata = '0;
   logic [CSR_DW-1:0]      csr_prdata;
   logic                   csr_pready;

   // predictor state: rule, grid size, line buffers, window, stream position
   logic [MASK_W-1:0] rule_survive = llag_pkg::RESET_SURVIVE;
   logic [MASK_W-1:0] rule_birth   = llag_pkg::RESET_BIRTH;
   logic [COL_W-1:0]  area_width   = llag_pkg::RESET_WIDTH;
   logic [ROW_W-1:0]  area_height  = llag_pkg::RESET_HEIGHT;
   bit                upper_cells [LINE_CELLS];
   bit                middle_cells [LINE_CELLS];
   logic [8:0]        moore_window = '0;
   logic [COL_W-1:0]  stream_col = '0;
   logic [ROW_W-1:0]  stream_row = '0;

   cell_result_type expected_cells [$];
   logic            hand_checked_next [$];
   int              cells_sent = 0;
   int              cells_taken = 0;
   int              error_count = 0;
   bit              stalls_on = 1'b0;

   probe_frame_type probe_table [3] = '{
      '{9'd12,  9'd8,   9'h007, 1'b1},   // dead cell, three neighbors: born
      '{9'd511, 9'd0,   9'h1FF, 1'b1},   // full block, survives on eight
      '{9'd0,   9'd511, 9'h000, 1'b1}    // empty block, born on zero
   };

   grid_setting_type boundary_settings [8] = '{
      '{9'd511, 9'd511, 9'd1,   12'd1},    // every rule bit set, single cell
      '{9'd0,   9'd0,   9'd2,   12'd2},
      '{9'd12,  9'd8,   9'd1,   12'd12},   // one column, tall
      '{9'd511, 9'd0,   9'd20,  12'd1},    // one row, wide
      '{9'd12,  9'd8,   9'd0,   12'd3},    // zero width: no results
      '{9'd12,  9'd8,   9'd4,   12'd0},    // zero height: no results
      '{9'd0,   9'd511, 9'd0,   12'd0},
      '{9'd6,   9'd255, 9'd2,   12'd1}
   };

   life_like_automaton_generation_unit #(
      .MAX_COLUMNS(LINE_CELLS),
      .MAX_ROWS   (FRAME_ROWS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [0] cell_alive
      .req_tuser  (req_tuser),   // [0] frame_start
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [0] next_alive, [9:1] cell_column, [21:10] cell_row
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #1 clock = ~clock;

   // next generation of one streamed item; queues the interior result if any
   function automatic void predict_cell(input logic alive, input logic frame_start);
      logic              up;
      logic              mid;
      logic              center;
      int                col_i;
      int                row_i;
      int                last_col;
      int                last_row;
      int                neighbors;
      logic [MASK_W-1:0] rule_bits;
      cell_result_type   res;
      if (frame_start) begin
         stream_col = '0;
         stream_row = '0;
      end
      col_i = stream_col;
      row_i = stream_row;
      last_col = int'(area_width) + 1;
      last_row = int'(area_height) + 1;

      // line buffers move down one row, newest column enters the window
      up = upper_cells[col_i];
      mid = middle_cells[col_i];
      upper_cells[col_i] = mid;
      middle_cells[col_i] = alive;
      moore_window = {moore_window[5:0], up, mid, alive};

      if (row_i >= 2 && row_i <= last_row && col_i >= 2 && col_i <= last_col) begin
         center = moore_window[4];
         neighbors = $countones(moore_window) - int'(center);
         rule_bits = center ? rule_survive : rule_birth;
         res.next_alive = rule_bits[neighbors];
         res.column = COL_W'(col_i - 2);
         res.row = ROW_W'(row_i - 2);
         res.last = (row_i == last_row && col_i == last_col);
         if (hand_checked_next.size() != 0) begin
            res.next_alive = hand_checked_next.pop_front();
         end
         expected_cells.push_back(res);
      end

      // raster advance, wrapping at the border, at the buffer depth or at the frame row limit
      if (col_i >= last_col || col_i + 1 >= LINE_CELLS) begin
         stream_col = '0;
         if (row_i >= last_row || row_i + 1 >= FRAME_ROWS) begin
            stream_row = '0;
         end else begin
            stream_row = ROW_W'(row_i + 1);
         end
      end else begin
         stream_col = COL_W'(col_i + 1);
      end
   endfunction

   // item monitor and result checker
   always @(posedge clock) begin
      cell_result_type got;
      cell_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_cell(req_tdata[0], req_tuser[0]);
            cells_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.next_alive = rsp_tdata[0];
            got.column = rsp_tdata[9:1];
            got.row = rsp_tdata[21:10];
            got.last = rsp_tlast;
            if (expected_cells.size() == 0) begin
               error_count++;
               $display("%0t: unexpected item: expected none, got alive %0b col %0d row %0d last %0b",
                        $time, got.next_alive, got.column, got.row, got.last);
            end else begin
               want = expected_cells.pop_front();
               if (got !== want) begin
                  error_count++;
                  $display("%0t: mismatch: expected alive %0b col %0d row %0d last %0b, got alive %0b col %0d row %0d last %0b",
                           $time, want.next_alive, want.column, want.row, want.last,
                           got.next_alive, got.column, got.row, got.last);
               end
            end
         end
      end
   end

   // result side: ready runs broken by stalls while stalls_on is set, mostly short
   initial begin
      int unsigned roll;
      while (reset) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (stalls_on) begin
            rsp_tready <= 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else if (roll < 95) begin
               repeat ($urandom_range(4, 12)) @(posedge clock);
            end else begin
               repeat ($urandom_range(20, 80)) @(posedge clock);
            end
         end
      end
   end

   function automatic int unsigned sender_gap(input bit idle_on);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // one item on req_*, then an optional gap
   task automatic send_cell(input logic alive, input logic frame_start, input bit idle_on);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_TDATA_W-1){1'b0}}, alive};
      req_tuser <= frame_start;
      do @(posedge clock); while (!req_tready);
      cells_sent++;
      gap = sender_gap(idle_on);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold the sender until every queued result has come back
   task automatic await_results();
      req_tvalid <= 1'b0;
      do @(posedge clock);
      while (cells_taken != cells_sent || expected_cells.size() != 0);
   endtask

   // one register access: setup phase, then access until pready
   task automatic csr_transfer(input logic is_write, input llag_pkg::reg_index_type idx,
                               input logic [CSR_DW-1:0] wdata,
                               output logic [CSR_DW-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
   endtask

   task automatic check_register(input llag_pkg::reg_index_type idx,
                                 input logic [CSR_DW-1:0] want);
      logic [CSR_DW-1:0] rdata;
      csr_transfer(1'b0, idx, '0, rdata);
      if (rdata !== want) begin
         error_count++;
         $display("%0t: register %s read: expected %0d, got %0d",
                  $time, idx.name(), want, rdata);
      end
   endtask

   // write a register (upper bits sometimes junk), track it, read it back
   task automatic set_register(input llag_pkg::reg_index_type idx,
                               input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] field_mask;
      logic [CSR_DW-1:0] wdata;
      logic [CSR_DW-1:0] rdata;
      field_mask = (idx == llag_pkg::REG_GRID_HEIGHT) ? 32'h0000_0FFF : 32'h0000_01FF;
      wdata = value & field_mask;
      if ($urandom_range(0, 1) != 0) begin
         wdata = wdata | ($urandom & ~field_mask);
      end
      csr_transfer(1'b1, idx, wdata, rdata);
      case (idx)
         llag_pkg::REG_SURVIVE_MASK: rule_survive = wdata[MASK_W-1:0];
         llag_pkg::REG_BIRTH_MASK:   rule_birth = wdata[MASK_W-1:0];
         llag_pkg::REG_GRID_WIDTH:   area_width = wdata[COL_W-1:0];
         llag_pkg::REG_GRID_HEIGHT:  area_height = wdata[ROW_W-1:0];
         default: ;
      endcase
      check_register(idx, wdata & field_mask);
   endtask

   // new rule and size, only once the unit has gone quiet
   task automatic configure(input grid_setting_type setting);
      await_results();
      repeat (SETTLE_TICKS) @(posedge clock);
      set_register(llag_pkg::REG_SURVIVE_MASK, CSR_DW'(setting.survive));
      set_register(llag_pkg::REG_BIRTH_MASK, CSR_DW'(setting.birth));
      set_register(llag_pkg::REG_GRID_WIDTH, CSR_DW'(setting.width));
      set_register(llag_pkg::REG_GRID_HEIGHT, CSR_DW'(setting.height));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // whole frames in the current setup; rough adds live borders and restarts
   task automatic stream_frames(input int frames, input bit idle_on,
                                input int unsigned density, input bit rough,
                                input int hold_at);
      int   row_len;
      int   rows;
      int   r;
      int   c;
      int   sent_here;
      logic alive;
      logic fs;
      row_len = ((int'(area_width) + 1 > LINE_CELLS - 1) ?
                 LINE_CELLS - 1 : int'(area_width) + 1) + 1;
      rows = ((int'(area_height) + 1 > FRAME_ROWS - 1) ?
              FRAME_ROWS - 1 : int'(area_height) + 1) + 1;
      sent_here = 0;
      for (int f = 0; f < frames; f++) begin
         r = 0;
         c = 0;
         while (r < rows) begin
            fs = (r == 0 && c == 0 && (f == 0 || $urandom_range(0, 1) != 0));
            // broken frame: restart mid-way with a new frame start
            if (rough && !fs && $urandom_range(0, 199) == 0) begin
               fs = 1'b1;
               r = 0;
               c = 0;
            end
            if (r == 0 || c == 0 || r == rows - 1 || c == row_len - 1) begin
               alive = rough ? ($urandom_range(0, 7) == 0) : 1'b0;
            end else begin
               alive = ($urandom_range(0, 99) < density);
            end
            send_cell(alive, fs, idle_on);
            sent_here++;
            if (sent_here == hold_at) begin
               await_results();
            end
            c++;
            if (c == row_len) begin
               c = 0;
               r++;
            end
         end
      end
   endtask

   // stimulus
   initial begin
      grid_setting_type setting;
      int               start_count;
      bit               small_grid;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // power-on register values
      check_register(llag_pkg::REG_SURVIVE_MASK, CSR_DW'(llag_pkg::RESET_SURVIVE));
      check_register(llag_pkg::REG_BIRTH_MASK, CSR_DW'(llag_pkg::RESET_BIRTH));
      check_register(llag_pkg::REG_GRID_WIDTH, CSR_DW'(llag_pkg::RESET_WIDTH));
      check_register(llag_pkg::REG_GRID_HEIGHT, CSR_DW'(llag_pkg::RESET_HEIGHT));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;

      // hand-checked 3x3 frames on a 1x1 area
      stalls_on = 1'b1;
      foreach (probe_table[i]) begin
         configure(grid_setting_type'{probe_table[i].survive, probe_table[i].birth,
                                      9'd1, 12'd1});
         hand_checked_next.push_back(probe_table[i].next_alive);
         for (int k = 0; k < 9; k++) begin
            send_cell(probe_table[i].pattern[k], k == 0, 1'b1);
         end
      end

      // extreme masks and degenerate sizes
      foreach (boundary_settings[i]) begin
         setting = boundary_settings[i];
         small_grid = (setting.width <= 20 && setting.height <= 20);
         stalls_on = small_grid;
         configure(setting);
         stream_frames(1, small_grid, $urandom_range(10, 90), 1'b0, -1);
      end

      // random rules, sizes and content
      start_count = cells_sent;
      while (cells_sent - start_count < RANDOM_CELLS) begin
         setting.survive = MASK_W'($urandom_range(0, 511));
         setting.birth = MASK_W'($urandom_range(0, 511));
         if ($urandom_range(0, 6) == 0) setting.survive = $urandom_range(0, 1) ? 9'd511 : 9'd0;
         if ($urandom_range(0, 6) == 0) setting.birth = $urandom_range(0, 1) ? 9'd511 : 9'd0;
         case ($urandom_range(0, 9))
            0: begin
               setting.width = COL_W'($urandom_range(13, 40));
               setting.height = ROW_W'($urandom_range(1, 4));
            end
            1: begin
               setting.width = COL_W'($urandom_range(0, 3));
               setting.height = ROW_W'($urandom_range(0, 3));
            end
            default: begin
               setting.width = COL_W'($urandom_range(1, 12));
               setting.height = ROW_W'($urandom_range(1, 8));
            end
         endcase
         stalls_on = ($urandom_range(0, 3) != 0);
         configure(setting);
         stream_frames(int'($urandom_range(1, 3)), $urandom_range(0, 3) != 0,
                       $urandom_range(5, 95), $urandom_range(0, 3) == 0,
                       (cells_sent == start_count || $urandom_range(0, 4) == 0) ?
                       int'($urandom_range(1, 20)) : -1);
      end

      // drain and report
      await_results();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (error_count == 0) begin
         $display("life_like_automaton_generation_unit_tb: PASS");
      end else begin
         $display("life_like_automaton_generation_unit_tb: FAIL");
      end
      $finish;
   end

   // run limit
   initial begin
      #4000000;
      $display("life_like_automaton_generation_unit_tb: FAIL");
      $finish;
   end

endmodule
